[hw/rtl/sdspi_pkg.sv]
// shared constants and types for the sd card spi host sequencer
package sdspi_pkg;
  localparam int BLOCK_BYTES = 512;
  localparam int WAKE_BYTES = 10;

  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;

  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_WAKE = 5'd1;
  localparam logic [4:0] PH_C_GO_IDLE = 5'd2;
  localparam logic [4:0] PH_C_IF_COND = 5'd3;
  localparam logic [4:0] PH_IF_TAIL = 5'd4;
  localparam logic [4:0] PH_C_APP_DET = 5'd5;
  localparam logic [4:0] PH_C_ACMD_DET = 5'd6;
  localparam logic [4:0] PH_C_APP_POLL = 5'd7;
  localparam logic [4:0] PH_C_ACMD_POLL = 5'd8;
  localparam logic [4:0] PH_C_CMD1_POLL = 5'd9;
  localparam logic [4:0] PH_C_READ_OCR = 5'd10;
  localparam logic [4:0] PH_OCR_TAIL = 5'd11;
  localparam logic [4:0] PH_C_BLOCKLEN = 5'd12;
  localparam logic [4:0] PH_C_READ = 5'd13;
  localparam logic [4:0] PH_TOKEN = 5'd14;
  localparam logic [4:0] PH_DATA = 5'd15;
  localparam logic [4:0] PH_CRC = 5'd16;
  localparam logic [4:0] PH_FINAL = 5'd17;

  localparam logic [3:0] POLL_STEP = 4'd7;

  localparam logic [1:0] CFG_IDLE_RETRY = 2'd0;
  localparam logic [1:0] CFG_OPCOND_RETRY = 2'd1;
  localparam logic [1:0] CFG_TOKEN_TIMEOUT = 2'd2;
  localparam logic [1:0] CFG_POLL_LIMIT = 2'd3;

  typedef struct packed {
    logic [15:0] idle_retry_limit;
    logic [15:0] opcond_retry_limit;
    logic [15:0] token_timeout;
    logic [7:0]  response_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       fast_clock;
    logic [7:0] read_data;
    logic       read_valid;
    logic       done_res;
    logic       failed;
    logic [1:0] card_kind;
  } res_t;
endpackage

[hw/rtl/sdspi_cfg_regs.sv]
// configuration register file
module sdspi_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output sdspi_pkg::cfg_t     cfg
);
  sdspi_pkg::cfg_t cfg_r;
  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_retry_limit <= 16'd511;
      cfg_r.opcond_retry_limit <= 16'd32767;
      cfg_r.token_timeout <= 16'hFFFF;
      cfg_r.response_poll_limit <= 8'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sdspi_pkg::CFG_IDLE_RETRY: cfg_r.idle_retry_limit <= cfg_data;
        sdspi_pkg::CFG_OPCOND_RETRY: cfg_r.opcond_retry_limit <= cfg_data;
        sdspi_pkg::CFG_TOKEN_TIMEOUT: cfg_r.token_timeout <= cfg_data;
        default: cfg_r.response_poll_limit <= cfg_data[7:0];
      endcase
    end
  end
endmodule

[hw/rtl/sdspi_seq_core.sv]
// protocol sequencer state and next-transfer logic
module sdspi_seq_core #(
  parameter int WAKE_BYTES = sdspi_pkg::WAKE_BYTES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  sdspi_pkg::cfg_t cfg,
  input  logic [1:0]      operation,
  input  logic [7:0]      rx_byte,
  input  logic [31:0]     block_number,
  input  logic [8:0]      offset,
  input  logic [9:0]      count,
  output sdspi_pkg::res_t res
);
  logic [4:0]  phase_r, phase_nxt;
  logic [3:0]  bstep_r, bstep_nxt;
  logic [15:0] retry_r, retry_nxt;
  logic [9:0]  bidx_r, bidx_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [9:0]  wlo_r, wlo_nxt, whi_r, whi_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic        fast_r, fast_nxt;
  logic [7:0]  tx;
  logic        done, fail, rvalid;
  logic [7:0]  lim;
  logic [10:0] wend;

  function automatic logic [7:0] cmd_byte(input logic [4:0] ph, input logic [3:0] bs,
                                          input logic [31:0] arg);
    logic [5:0] num;
    unique case (ph)
      sdspi_pkg::PH_C_GO_IDLE: num = 6'd0;
      sdspi_pkg::PH_C_IF_COND: num = 6'd8;
      sdspi_pkg::PH_C_APP_DET, sdspi_pkg::PH_C_APP_POLL: num = 6'd55;
      sdspi_pkg::PH_C_ACMD_DET, sdspi_pkg::PH_C_ACMD_POLL: num = 6'd41;
      sdspi_pkg::PH_C_CMD1_POLL: num = 6'd1;
      sdspi_pkg::PH_C_READ_OCR: num = 6'd58;
      sdspi_pkg::PH_C_BLOCKLEN: num = 6'd16;
      default: num = 6'd17;
    endcase
    case (bs)
      4'd1: cmd_byte = {2'b01, num};
      4'd2: cmd_byte = arg[31:24];
      4'd3: cmd_byte = arg[23:16];
      4'd4: cmd_byte = arg[15:8];
      4'd5: cmd_byte = arg[7:0];
      4'd6: cmd_byte = (ph == sdspi_pkg::PH_C_GO_IDLE) ? 8'h95 :
                       (ph == sdspi_pkg::PH_C_IF_COND) ? 8'h87 : 8'hFF;
      default: cmd_byte = 8'hFF;
    endcase
  endfunction

  always_comb begin
    logic [4:0] cph;
    logic [31:0] carg;
    logic cmd_start, is_cmd;
    phase_nxt = phase_r; bstep_nxt = bstep_r; retry_nxt = retry_r; bidx_nxt = bidx_r;
    kind_nxt = kind_r; wlo_nxt = wlo_r; whi_nxt = whi_r; arg_nxt = arg_r; fast_nxt = fast_r;
    tx = 8'hFF; done = 1'b0; fail = 1'b0; rvalid = 1'b0;
    cmd_start = 1'b0; cph = sdspi_pkg::PH_C_GO_IDLE; carg = 32'd0;
    lim = (cfg.response_poll_limit == 8'd0) ? 8'd1 : cfg.response_poll_limit;
    wend = {2'b0, offset} + {1'b0, count};
    is_cmd = (phase_r >= sdspi_pkg::PH_C_GO_IDLE && phase_r <= sdspi_pkg::PH_C_IF_COND) ||
             (phase_r >= sdspi_pkg::PH_C_APP_DET && phase_r <= sdspi_pkg::PH_C_READ_OCR) ||
             phase_r == sdspi_pkg::PH_C_BLOCKLEN || phase_r == sdspi_pkg::PH_C_READ;
    if (operation == sdspi_pkg::OP_INIT) begin
      kind_nxt = 2'd0; fast_nxt = 1'b0;
      phase_nxt = sdspi_pkg::PH_WAKE; bidx_nxt = 10'd0;
    end else if (operation == sdspi_pkg::OP_READ) begin
      wlo_nxt = {1'b0, offset};
      whi_nxt = (wend > 11'd512) ? 10'd512 : wend[9:0];
      cmd_start = 1'b1; cph = sdspi_pkg::PH_C_READ;
      carg = (kind_r == 2'd3) ? block_number : {block_number[22:0], 9'd0};
    end else if (is_cmd) begin
      if (bstep_r < sdspi_pkg::POLL_STEP) begin
        bstep_nxt = bstep_r + 4'd1; bidx_nxt = 10'd0;
        tx = cmd_byte(phase_r, bstep_r + 4'd1, arg_r);
      end else begin
        bidx_nxt = bidx_r + 10'd1;
        if (rx_byte != 8'hFF || (bidx_r + 10'd1) >= {2'b0, lim}) begin
          unique case (phase_r)
            sdspi_pkg::PH_C_GO_IDLE:
              if (rx_byte == 8'h01) begin
                cmd_start = 1'b1; cph = sdspi_pkg::PH_C_IF_COND; carg = 32'h1AA;
              end else if (retry_r >= cfg.idle_retry_limit) begin
                done = 1'b1; fail = 1'b1;
              end else begin
                retry_nxt = retry_r + 16'd1; cmd_start = 1'b1;
              end
            sdspi_pkg::PH_C_IF_COND:
              if (!rx_byte[2]) begin
                phase_nxt = sdspi_pkg::PH_IF_TAIL; bidx_nxt = 10'd0;
              end else begin
                cmd_start = 1'b1; cph = sdspi_pkg::PH_C_APP_DET;
              end
            sdspi_pkg::PH_C_APP_DET: begin
              cmd_start = 1'b1; cph = sdspi_pkg::PH_C_ACMD_DET;
            end
            sdspi_pkg::PH_C_ACMD_DET: begin
              if (!rx_byte[2]) kind_nxt = 2'd1;
              retry_nxt = 16'd0; cmd_start = 1'b1;
              cph = (!rx_byte[2] || kind_r != 2'd0) ? sdspi_pkg::PH_C_APP_POLL
                                                    : sdspi_pkg::PH_C_CMD1_POLL;
            end
            sdspi_pkg::PH_C_APP_POLL: begin
              cmd_start = 1'b1; cph = sdspi_pkg::PH_C_ACMD_POLL;
              carg = (kind_r >= 2'd2) ? 32'h40000000 : 32'd0;
            end
            sdspi_pkg::PH_C_ACMD_POLL, sdspi_pkg::PH_C_CMD1_POLL:
              if (!rx_byte[0]) begin
                cmd_start = 1'b1;
                if (kind_r >= 2'd2) cph = sdspi_pkg::PH_C_READ_OCR;
                else begin
                  cph = sdspi_pkg::PH_C_BLOCKLEN; carg = 32'(sdspi_pkg::BLOCK_BYTES);
                end
              end else if (retry_r >= cfg.opcond_retry_limit) begin
                done = 1'b1; fail = 1'b1;
              end else begin
                retry_nxt = retry_r + 16'd1; cmd_start = 1'b1;
                cph = (kind_r != 2'd0) ? sdspi_pkg::PH_C_APP_POLL : sdspi_pkg::PH_C_CMD1_POLL;
              end
            sdspi_pkg::PH_C_READ_OCR:
              if (rx_byte != 8'd0) begin
                done = 1'b1; fail = 1'b1;
              end else begin
                phase_nxt = sdspi_pkg::PH_OCR_TAIL; bidx_nxt = 10'd0;
              end
            sdspi_pkg::PH_C_BLOCKLEN:
              if (rx_byte != 8'd0) begin
                done = 1'b1; fail = 1'b1;
              end else begin
                fast_nxt = 1'b1; done = 1'b1;
              end
            default:
              if (rx_byte != 8'd0) begin
                done = 1'b1; fail = 1'b1;
              end else begin
                retry_nxt = 16'd0; phase_nxt = sdspi_pkg::PH_TOKEN; bidx_nxt = 10'd0;
              end
          endcase
        end
      end
    end else begin
      unique case (phase_r)
        sdspi_pkg::PH_WAKE:
          if ((bidx_r + 10'd1) >= 10'(WAKE_BYTES)) begin
            retry_nxt = 16'd0; cmd_start = 1'b1;
          end else bidx_nxt = bidx_r + 10'd1;
        sdspi_pkg::PH_IF_TAIL:
          if (bidx_r == 10'd2 && !rx_byte[0]) begin
            done = 1'b1; fail = 1'b1;
          end else if (bidx_r >= 10'd3) begin
            if (rx_byte != 8'hAA) begin
              done = 1'b1; fail = 1'b1;
            end else begin
              kind_nxt = 2'd2; retry_nxt = 16'd0; cmd_start = 1'b1;
              cph = sdspi_pkg::PH_C_APP_POLL;
            end
          end else bidx_nxt = bidx_r + 10'd1;
        sdspi_pkg::PH_OCR_TAIL: begin
          if (bidx_r == 10'd0 && rx_byte[6]) kind_nxt = 2'd3;
          if (bidx_r >= 10'd3) begin
            cmd_start = 1'b1; cph = sdspi_pkg::PH_C_BLOCKLEN;
            carg = 32'(sdspi_pkg::BLOCK_BYTES);
          end else bidx_nxt = bidx_r + 10'd1;
        end
        sdspi_pkg::PH_TOKEN:
          if (rx_byte == 8'hFE) begin
            phase_nxt = sdspi_pkg::PH_DATA; bidx_nxt = 10'd0;
          end else if (retry_r >= cfg.token_timeout) begin
            done = 1'b1; fail = 1'b1;
          end else retry_nxt = retry_r + 16'd1;
        sdspi_pkg::PH_DATA: begin
          rvalid = (bidx_r >= wlo_r) && (bidx_r < whi_r);
          bidx_nxt = bidx_r + 10'd1;
          if ((bidx_r + 10'd1) >= 10'(sdspi_pkg::BLOCK_BYTES)) begin
            phase_nxt = sdspi_pkg::PH_CRC; bstep_nxt = 4'd0;
          end
        end
        sdspi_pkg::PH_CRC:
          if (bstep_r == 4'd0) bstep_nxt = 4'd1;
          else phase_nxt = sdspi_pkg::PH_FINAL;
        sdspi_pkg::PH_FINAL: done = 1'b1;
        default: ;
      endcase
    end
    if (cmd_start) begin
      phase_nxt = cph; bstep_nxt = 4'd0; bidx_nxt = 10'd0; arg_nxt = carg;
      tx = cmd_byte(cph, 4'd0, carg);
    end
    if (done) phase_nxt = sdspi_pkg::PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdspi_pkg::PH_IDLE; bstep_r <= 4'd0; retry_r <= 16'd0; bidx_r <= 10'd0;
      kind_r <= 2'd0; wlo_r <= 10'd0; whi_r <= 10'd0; arg_r <= 32'd0; fast_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt; bstep_r <= bstep_nxt; retry_r <= retry_nxt; bidx_r <= bidx_nxt;
      kind_r <= kind_nxt; wlo_r <= wlo_nxt; whi_r <= whi_nxt; arg_r <= arg_nxt;
      fast_r <= fast_nxt;
    end
  end

  always_comb begin
    res.tx_byte = tx;
    res.chip_select = !(phase_nxt == sdspi_pkg::PH_IDLE || phase_nxt == sdspi_pkg::PH_WAKE ||
                        phase_nxt == sdspi_pkg::PH_FINAL);
    res.fast_clock = fast_nxt;
    res.read_data = rvalid ? rx_byte : 8'd0;
    res.read_valid = rvalid;
    res.done_res = done;
    res.failed = fail;
    res.card_kind = kind_nxt;
  end
endmodule

[hw/rtl/sd_card_spi_host_sequencer.sv]
// top level of the sd card spi host sequencer
// One transaction in gives one transaction out: a request or the byte received from the
// previous transfer enters an input register, the sequencer decides the next transfer in
// combinational logic, and the result sits in an output register. One item per cycle is
// sustained while out_stall is low. The output register holds while out_stall is high and
// the input side stalls only when both registers are full.
module sd_card_spi_host_sequencer #(
  parameter int WAKE_BYTES = sdspi_pkg::WAKE_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_rx_byte,
  input  logic [31:0] in_block_number,
  input  logic [8:0]  in_offset,
  input  logic [9:0]  in_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_chip_select,
  output logic        out_fast_clock,
  output logic [7:0]  out_read_data,
  output logic        out_read_valid,
  output logic        out_done_res,
  output logic        out_failed,
  output logic [1:0]  out_card_kind,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  sdspi_pkg::cfg_t cfg;
  sdspi_pkg::res_t res, res_r;
  logic        iv_r, ov_r, step;
  logic [1:0]  op_r;
  logic [7:0]  rx_r;
  logic [31:0] blk_r;
  logic [8:0]  off_r;
  logic [9:0]  cnt_r;

  assign step = iv_r && (!ov_r || !out_stall);
  assign in_stall = iv_r && !step;

  sdspi_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
  );

  sdspi_seq_core #(.WAKE_BYTES(WAKE_BYTES)) u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .cfg(cfg), .operation(op_r), .rx_byte(rx_r),
    .block_number(blk_r), .offset(off_r), .count(cnt_r), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (!in_stall) iv_r <= in_valid;
      if (step) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
    if (!in_stall && in_valid) begin
      op_r <= in_operation; rx_r <= in_rx_byte; blk_r <= in_block_number;
      off_r <= in_offset; cnt_r <= in_count;
    end
    if (step) res_r <= res;
  end

  assign out_valid = ov_r;
  assign out_tx_byte = res_r.tx_byte;
  assign out_chip_select = res_r.chip_select;
  assign out_fast_clock = res_r.fast_clock;
  assign out_read_data = res_r.read_data;
  assign out_read_valid = res_r.read_valid;
  assign out_done_res = res_r.done_res;
  assign out_failed = res_r.failed;
  assign out_card_kind = res_r.card_kind;
endmodule

[tb/sv/sd_card_spi_host_sequencer_tb.sv]
// self-checking testbench for the sd card spi host sequencer with a card-like byte source
module sd_card_spi_host_sequencer_tb;

  localparam logic [1:0] OP_RX = 2'd2;
  localparam logic [1:0] OP_RX_ALT = 2'd3;
  localparam int STALL_LIMIT = 20000;

  class seq_scoreboard;
    logic [15:0] idle_lim = 16'd511;
    logic [15:0] opc_lim = 16'd32767;
    logic [15:0] tok_lim = 16'd65535;
    logic [7:0]  poll_lim = 8'd10;
    logic [4:0]  phase = sdspi_pkg::PH_IDLE;
    logic [3:0]  step = '0;
    logic [15:0] retries = '0;
    logic [9:0]  idx = '0;
    logic [1:0]  kind = '0;
    logic [19:0] window = '0;
    logic [31:0] arg = '0;
    bit          fast = 0;
    sdspi_pkg::res_t cur;
    sdspi_pkg::res_t pending[$];
    int          errors = 0;

    function void set_config(logic [1:0] index, logic [15:0] data);
      case (index)
        sdspi_pkg::CFG_IDLE_RETRY: idle_lim = data;
        sdspi_pkg::CFG_OPCOND_RETRY: opc_lim = data;
        sdspi_pkg::CFG_TOKEN_TIMEOUT: tok_lim = data;
        sdspi_pkg::CFG_POLL_LIMIT: poll_lim = data[7:0];
      endcase
    endfunction

    function bit is_cmd();
      return phase inside {sdspi_pkg::PH_C_GO_IDLE, sdspi_pkg::PH_C_IF_COND,
                           sdspi_pkg::PH_C_APP_DET, sdspi_pkg::PH_C_ACMD_DET,
                           sdspi_pkg::PH_C_APP_POLL, sdspi_pkg::PH_C_ACMD_POLL,
                           sdspi_pkg::PH_C_CMD1_POLL, sdspi_pkg::PH_C_READ_OCR,
                           sdspi_pkg::PH_C_BLOCKLEN, sdspi_pkg::PH_C_READ};
    endfunction

    function logic [7:0] cmd_code();
      case (phase)
        sdspi_pkg::PH_C_GO_IDLE: return 8'd0;
        sdspi_pkg::PH_C_IF_COND: return 8'd8;
        sdspi_pkg::PH_C_APP_DET, sdspi_pkg::PH_C_APP_POLL: return 8'd55;
        sdspi_pkg::PH_C_ACMD_DET, sdspi_pkg::PH_C_ACMD_POLL: return 8'd41;
        sdspi_pkg::PH_C_CMD1_POLL: return 8'd1;
        sdspi_pkg::PH_C_READ_OCR: return 8'd58;
        sdspi_pkg::PH_C_BLOCKLEN: return 8'd16;
        default: return 8'd17;
      endcase
    endfunction

    function logic [7:0] cmd_byte();
      if (step == 4'd1) return 8'h40 | cmd_code();
      if (step >= 4'd2 && step <= 4'd5) return 8'(arg >> (8 * (5 - step)));
      if (step == 4'd6 && phase == sdspi_pkg::PH_C_GO_IDLE) return 8'h95;
      if (step == 4'd6 && phase == sdspi_pkg::PH_C_IF_COND) return 8'h87;
      return 8'hFF;
    endfunction

    function void start_cmd(logic [4:0] ph, logic [31:0] a);
      phase = ph;
      step = '0;
      idx = '0;
      arg = a;
      cur.tx_byte = cmd_byte();
    endfunction

    function void end_op(bit fail);
      phase = sdspi_pkg::PH_IDLE;
      cur.done_res = 1;
      cur.failed = fail;
      cur.tx_byte = 8'hFF;
    endfunction

    function void start_opcond();
      if (kind != 2'd0) start_cmd(sdspi_pkg::PH_C_APP_POLL, '0);
      else start_cmd(sdspi_pkg::PH_C_CMD1_POLL, '0);
    endfunction

    function void start_tail(logic [4:0] ph);
      phase = ph;
      idx = '0;
      cur.tx_byte = 8'hFF;
    endfunction

    function void take_response(logic [7:0] r);
      case (phase)
        sdspi_pkg::PH_C_GO_IDLE:
          if (r == 8'h01) start_cmd(sdspi_pkg::PH_C_IF_COND, 32'h1AA);
          else if (retries >= idle_lim) end_op(1);
          else begin
            retries++;
            start_cmd(sdspi_pkg::PH_C_GO_IDLE, '0);
          end
        sdspi_pkg::PH_C_IF_COND:
          if (!r[2]) start_tail(sdspi_pkg::PH_IF_TAIL);
          else start_cmd(sdspi_pkg::PH_C_APP_DET, '0);
        sdspi_pkg::PH_C_APP_DET: start_cmd(sdspi_pkg::PH_C_ACMD_DET, '0);
        sdspi_pkg::PH_C_ACMD_DET: begin
          if (!r[2]) kind = 2'd1;
          retries = '0;
          start_opcond();
        end
        sdspi_pkg::PH_C_APP_POLL:
          start_cmd(sdspi_pkg::PH_C_ACMD_POLL, kind >= 2'd2 ? 32'h40000000 : 32'h0);
        sdspi_pkg::PH_C_ACMD_POLL, sdspi_pkg::PH_C_CMD1_POLL:
          if (!r[0]) begin
            if (kind >= 2'd2) start_cmd(sdspi_pkg::PH_C_READ_OCR, '0);
            else start_cmd(sdspi_pkg::PH_C_BLOCKLEN, 32'(sdspi_pkg::BLOCK_BYTES));
          end else if (retries >= opc_lim) end_op(1);
          else begin
            retries++;
            start_opcond();
          end
        sdspi_pkg::PH_C_READ_OCR:
          if (r != 8'h00) end_op(1);
          else start_tail(sdspi_pkg::PH_OCR_TAIL);
        sdspi_pkg::PH_C_BLOCKLEN:
          if (r != 8'h00) end_op(1);
          else begin
            fast = 1;
            end_op(0);
          end
        default:
          if (r != 8'h00) end_op(1);
          else begin
            retries = '0;
            start_tail(sdspi_pkg::PH_TOKEN);
          end
      endcase
    endfunction

    function void take_byte(logic [7:0] rx);
      logic [7:0] lim;
      if (is_cmd()) begin
        if (step < sdspi_pkg::POLL_STEP) begin
          step++;
          idx = '0;
          cur.tx_byte = cmd_byte();
        end else begin
          idx++;
          lim = (poll_lim == 8'd0) ? 8'd1 : poll_lim;
          if (rx != 8'hFF || idx >= {2'b0, lim}) take_response(rx);
          else cur.tx_byte = 8'hFF;
        end
        return;
      end
      case (phase)
        sdspi_pkg::PH_WAKE: begin
          idx++;
          if (idx >= 10'(sdspi_pkg::WAKE_BYTES)) begin
            retries = '0;
            start_cmd(sdspi_pkg::PH_C_GO_IDLE, '0);
          end
        end
        sdspi_pkg::PH_IF_TAIL:
          if (idx == 10'd2 && !rx[0]) end_op(1);
          else if (idx >= 10'd3) begin
            if (rx != 8'hAA) end_op(1);
            else begin
              kind = 2'd2;
              retries = '0;
              start_opcond();
            end
          end else idx++;
        sdspi_pkg::PH_OCR_TAIL: begin
          if (idx == 10'd0 && rx[6]) kind = 2'd3;
          if (idx >= 10'd3) start_cmd(sdspi_pkg::PH_C_BLOCKLEN, 32'(sdspi_pkg::BLOCK_BYTES));
          else idx++;
        end
        sdspi_pkg::PH_TOKEN:
          if (rx == 8'hFE) start_tail(sdspi_pkg::PH_DATA);
          else if (retries >= tok_lim) end_op(1);
          else retries++;
        sdspi_pkg::PH_DATA: begin
          if (idx >= window[9:0] && idx < window[19:10]) begin
            cur.read_data = rx;
            cur.read_valid = 1;
          end
          idx++;
          if (idx >= 10'(sdspi_pkg::BLOCK_BYTES)) begin
            phase = sdspi_pkg::PH_CRC;
            step = '0;
          end
        end
        sdspi_pkg::PH_CRC:
          if (step == 4'd0) step = 4'd1;
          else phase = sdspi_pkg::PH_FINAL;
        sdspi_pkg::PH_FINAL: end_op(0);
        default: ;
      endcase
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] rx, logic [31:0] blk,
                             logic [8:0] off, logic [9:0] cnt);
      logic [10:0] stop;
      cur = '0;
      cur.tx_byte = 8'hFF;
      if (op == sdspi_pkg::OP_INIT) begin
        kind = '0;
        fast = 0;
        start_tail(sdspi_pkg::PH_WAKE);
      end else if (op == sdspi_pkg::OP_READ) begin
        stop = {2'b0, off} + {1'b0, cnt};
        if (stop > 11'(sdspi_pkg::BLOCK_BYTES)) stop = 11'(sdspi_pkg::BLOCK_BYTES);
        window = {stop[9:0], 1'b0, off};
        start_cmd(sdspi_pkg::PH_C_READ, kind == 2'd3 ? blk : {blk[22:0], 9'd0});
      end else take_byte(rx);
      cur.chip_select = !(phase inside {sdspi_pkg::PH_IDLE, sdspi_pkg::PH_WAKE,
                                        sdspi_pkg::PH_FINAL});
      cur.fast_clock = fast;
      cur.card_kind = kind;
      pending.push_back(cur);
    endfunction

    function void check_result(sdspi_pkg::res_t got);
      sdspi_pkg::res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.tx_byte !== want.tx_byte || got.chip_select !== want.chip_select ||
          got.fast_clock !== want.fast_clock || got.read_data !== want.read_data ||
          got.read_valid !== want.read_valid || got.done_res !== want.done_res ||
          got.failed !== want.failed || got.card_kind !== want.card_kind) begin
        errors++;
        if (errors <= 10) $display("mismatch expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [7:0]  in_rx_byte = '0;
  logic [31:0] in_block_number = '0;
  logic [8:0]  in_offset = '0;
  logic [9:0]  in_count = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [7:0]  out_tx_byte;
  logic        out_chip_select;
  logic        out_fast_clock;
  logic [7:0]  out_read_data;
  logic        out_read_valid;
  logic        out_done_res;
  logic        out_failed;
  logic [1:0]  out_card_kind;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  seq_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  bit hold_req = 0;
  int quiet_cycles = 0;

  sd_card_spi_host_sequencer i_dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_tx_byte, out_chip_select, out_fast_clock, out_read_data,
                       out_read_valid, out_done_res, out_failed, out_card_kind});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic [7:0] rx, logic [31:0] blk,
                           logic [8:0] off, logic [9:0] cnt);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 0;
    end
    @(negedge clk);
    in_valid <= 1;
    in_operation <= op;
    in_rx_byte <= rx;
    in_block_number <= blk;
    in_offset <= off;
    in_count <= cnt;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, rx, blk, off, cnt);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] index, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_config(index, data);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic write_all(logic [15:0] idle_n, logic [15:0] opc_n, logic [15:0] tok_n,
                           logic [7:0] poll_n);
    drain();
    write_cfg(sdspi_pkg::CFG_IDLE_RETRY, idle_n);
    write_cfg(sdspi_pkg::CFG_OPCOND_RETRY, opc_n);
    write_cfg(sdspi_pkg::CFG_TOKEN_TIMEOUT, tok_n);
    write_cfg(sdspi_pkg::CFG_POLL_LIMIT, {8'h00, poll_n});
  endtask

  // plausible byte from a card given where the sequencer stands
  function automatic logic [7:0] card_reply();
    logic [7:0] noise;
    noise = 8'($urandom_range(255));
    if ($urandom_range(99) < 8) return noise;
    if (sb.is_cmd()) begin
      if (sb.step < sdspi_pkg::POLL_STEP) return noise;
      if ($urandom_range(99) < 30) return 8'hFF;
      case (sb.phase)
        sdspi_pkg::PH_C_GO_IDLE: return ($urandom_range(99) < 75) ? 8'h01 : 8'h00;
        sdspi_pkg::PH_C_IF_COND, sdspi_pkg::PH_C_ACMD_DET:
          return $urandom_range(1) ? 8'h05 : 8'h01;
        sdspi_pkg::PH_C_APP_DET, sdspi_pkg::PH_C_APP_POLL: return 8'h01;
        sdspi_pkg::PH_C_ACMD_POLL, sdspi_pkg::PH_C_CMD1_POLL:
          return $urandom_range(1) ? 8'h00 : 8'h01;
        default: return ($urandom_range(99) < 90) ? 8'h00 : 8'h01;
      endcase
    end
    case (sb.phase)
      sdspi_pkg::PH_IF_TAIL:
        if (sb.idx == 10'd2) return {noise[7:1], 1'b1};
        else if (sb.idx == 10'd3) return 8'hAA;
        else return noise;
      sdspi_pkg::PH_TOKEN: return ($urandom_range(99) < 30) ? 8'hFE : 8'hFF;
      default: return noise;
    endcase
  endfunction

  task automatic send_read();
    logic [9:0] cnt;
    case ($urandom_range(9))
      0: cnt = 10'd0;
      1: cnt = 10'd512;
      2: cnt = 10'($urandom_range(512));
      default: cnt = 10'($urandom_range(16));
    endcase
    send_item(sdspi_pkg::OP_READ, 8'($urandom_range(255)), $urandom,
              9'($urandom_range(511)), cnt);
  endtask

  task automatic run_random(int items);
    int n;
    for (n = 0; n < items; n++) begin
      if (sb.phase == sdspi_pkg::PH_IDLE) begin
        case ($urandom_range(9))
          0: send_item($urandom_range(1) ? OP_RX : OP_RX_ALT, 8'($urandom_range(255)),
                       $urandom, 9'($urandom_range(511)), 10'($urandom_range(1023)));
          1, 2, 3, 4: send_item(sdspi_pkg::OP_INIT, 8'($urandom_range(255)), $urandom,
                                9'($urandom_range(511)), 10'($urandom_range(1023)));
          default: send_read();
        endcase
      end else if ($urandom_range(999) < 3) begin
        if ($urandom_range(1)) send_read();
        else send_item(sdspi_pkg::OP_INIT, 8'($urandom_range(255)), $urandom,
                       9'($urandom_range(511)), '0);
      end else begin
        send_item($urandom_range(19) == 0 ? OP_RX_ALT : OP_RX, card_reply(), $urandom,
                  9'($urandom_range(511)), 10'($urandom_range(1023)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed corners
    send_item(OP_RX, 8'h00, '0, '0, '0);
    send_item(OP_RX_ALT, 8'hFF, 32'hFFFFFFFF, 9'h1FF, 10'd512);
    send_item(sdspi_pkg::OP_READ, 8'h00, 32'hFFFFFFFF, 9'h1FF, 10'd512);
    repeat (8) send_item(OP_RX, 8'hFF, '0, '0, '0);
    send_item(OP_RX, 8'h00, '0, '0, '0);
    send_item(sdspi_pkg::OP_READ, 8'hFF, 32'h0, 9'd0, 10'd0);
    send_item(sdspi_pkg::OP_INIT, 8'h00, 32'h12345678, 9'd0, 10'd0);
    repeat (12) send_item(OP_RX, 8'hFF, '0, '0, '0);
    drain();

    write_all(16'd0, 16'd0, 16'd0, 8'd1);
    tx_idle_pct = 6;
    rx_idle_pct = 63;
    run_random(150);

    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
    tx_idle_pct = 63;
    rx_idle_pct = 6;
    run_random(150);

    write_all(16'd3, 16'd5, 16'd20, 8'd4);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(50);
    hold_req = 1;
    run_random(100);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

[sim.f]
hw/rtl/sdspi_pkg.sv
hw/rtl/sdspi_cfg_regs.sv
hw/rtl/sdspi_seq_core.sv
hw/rtl/sd_card_spi_host_sequencer.sv
tb/sv/sd_card_spi_host_sequencer_tb.sv
